// ----- design/mcfd_pkg.sv -----
// Shared types, constants and helper function for the motor command frame decoder.
package mcfd_pkg;

   localparam int FRAME_LEN = 4;
   localparam int IDX_W     = $clog2(FRAME_LEN);
   localparam int COUNT_W   = 3;
   localparam logic [COUNT_W-1:0] COUNT_MAX = 3'd7;

   localparam logic KIND_BYTE = 1'b0;
   localparam logic KIND_IDLE = 1'b1;

   localparam logic [7:0] HDR       = 8'hA5;
   localparam logic [7:0] TGT_BLDC  = 8'h25;
   localparam logic [7:0] TGT_STEP  = 8'h35;
   localparam logic [7:0] SEL_DUTY  = 8'h15;
   localparam logic [7:0] SEL_FREQ  = 8'h25;
   localparam logic [7:0] SEL_THIRD = 8'h35;
   localparam logic [7:0] SEL_RUN   = 8'h45;
   localparam logic [7:0] SEL_DIR   = 8'h55;
   localparam logic [7:0] SEL_MICRO = 8'h65;
   localparam logic [7:0] VAL_ON    = 8'h15;
   localparam logic [7:0] VAL_OFF   = 8'h25;

   localparam logic [1:0] TW_NONE = 2'd0;
   localparam logic [1:0] TW_ON   = 2'd1;
   localparam logic [1:0] TW_OFF  = 2'd2;

   localparam logic [1:0] LAST_NONE = 2'd0;
   localparam logic [1:0] LAST_BLDC = 2'd1;
   localparam logic [1:0] LAST_STEP = 2'd2;

   localparam int RSP_W = 72;

   typedef struct packed {
      logic       kind;
      logic [7:0] rx_byte;
   } item_type;

   typedef struct packed {
      logic [FRAME_LEN-1:0][7:0] bytes;
      logic                      full;
   } frame_type;

   // first member sits in the highest bits, so fields run from last to first
   typedef struct packed {
      logic       applied;
      logic [1:0] last_target;
      logic [7:0] step_microstep;
      logic [1:0] step_dir;
      logic [1:0] step_run;
      logic [7:0] step_pulses;
      logic [7:0] step_freq;
      logic [7:0] step_duty_pct;
      logic [1:0] bldc_run;
      logic [7:0] bldc_volt;
      logic [7:0] bldc_freq;
      logic [7:0] bldc_duty_pct;
   } result_type;

   function automatic logic [1:0] two_way(input logic [7:0] v);
      logic [1:0] r;
      r = TW_NONE;
      if (v == VAL_ON) begin
         r = TW_ON;
      end else if (v == VAL_OFF) begin
         r = TW_OFF;
      end
      return r;
   endfunction

endpackage

// ----- design/motor_command_frame_decoder_top.sv -----
// Top level of the motor command frame decoder.
//
// channel | direction | handshake             | payload
// req     | in        | req_tvalid/req_tready | tdata: rx_byte; tuser: kind
// rsp     | out       | rsp_tvalid/rsp_tready | tdata: settings snapshot, applied
//
// One transaction per cycle sustained unless an idle waits on a stalled rsp; the
// input register feeds the frame store and decoder, whose result register drives
// rsp. An idle's snapshot passes the input and then the result register.
// Reset clears byte count, settings and valid flags; frame bytes are not cleared.
// A stalled rsp holds idle transactions in the input register; byte
// transactions keep flowing while a snapshot waits.
module motor_command_frame_decoder_top (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,  // [7:0] rx_byte
   input  logic        req_tuser,  // [0] kind
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [71:0] rsp_tdata   // [7:0] bldc_duty_pct, [15:8] bldc_freq,
                                   // [23:16] bldc_volt, [25:24] bldc_run,
                                   // [33:26] step_duty_pct, [41:34] step_freq,
                                   // [49:42] step_pulses, [51:50] step_run,
                                   // [53:52] step_dir, [61:54] step_microstep,
                                   // [63:62] last_target, [64] applied, rest zero
);

   mcfd_pkg::item_type   item;
   mcfd_pkg::frame_type  frame;
   mcfd_pkg::result_type result;
   logic                 item_valid;
   logic                 out_free;
   logic                 take;
   logic                 byte_we;
   logic                 fire;

   assign out_free = !rsp_tvalid || rsp_tready;
   assign take     = item_valid &&
                     ((item.kind == mcfd_pkg::KIND_BYTE) || out_free);
   assign byte_we  = take && (item.kind == mcfd_pkg::KIND_BYTE);
   assign fire     = take && (item.kind == mcfd_pkg::KIND_IDLE);

   assign rsp_tdata = {(mcfd_pkg::RSP_W - $bits(result))'(0), result};

   mcfd_in_reg u_in_reg (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .take       (take),
      .item_valid (item_valid),
      .item       (item)
   );

   mcfd_frame_buf u_frame_buf (
      .clock    (clock),
      .reset    (reset),
      .byte_we  (byte_we),
      .idle_clr (fire),
      .rx_byte  (item.rx_byte),
      .frame    (frame)
   );

   mcfd_decoder u_decoder (
      .clock      (clock),
      .reset      (reset),
      .fire       (fire),
      .frame      (frame),
      .rsp_tready (rsp_tready),
      .rsp_valid  (rsp_tvalid),
      .result     (result)
   );

   a_idle_gives_rsp: assert property (@(posedge clock) disable iff (reset)
      fire |=> rsp_tvalid)
      else $error("idle transaction produced no response");

   a_byte_no_rsp: assert property (@(posedge clock) disable iff (reset)
      byte_we && !rsp_tvalid |=> !rsp_tvalid)
      else $error("byte transaction produced a response");

   a_applied_target: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && result.applied |-> result.last_target != mcfd_pkg::LAST_NONE)
      else $error("applied command without a target");

   a_idle_held: assert property (@(posedge clock) disable iff (reset)
      item_valid && (item.kind == mcfd_pkg::KIND_IDLE) && !out_free |-> !req_tready)
      else $error("input taken while idle transaction stalled");

endmodule

// ----- design/mcfd_in_reg.sv -----
// Input register stage holding one request transaction.
module mcfd_in_reg (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   input  logic [7:0]         req_tdata,
   input  logic               req_tuser,
   input  logic               take,
   output logic               item_valid,
   output mcfd_pkg::item_type item
);

   logic               valid_ff;
   logic               valid_in;
   mcfd_pkg::item_type item_ff;

   assign req_tready = !valid_ff || take;
   assign item_valid = valid_ff;
   assign item       = item_ff;

   always_comb begin
      valid_in = valid_ff;
      if (req_tready) begin
         valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      if (req_tvalid && req_tready) begin
         item_ff.kind    <= req_tuser;
         item_ff.rx_byte <= req_tdata;
      end
   end

endmodule

// ----- design/mcfd_frame_buf.sv -----
// Frame byte store and saturating byte count.
module mcfd_frame_buf (
   input  logic                clock,
   input  logic                reset,
   input  logic                byte_we,
   input  logic                idle_clr,
   input  logic [7:0]          rx_byte,
   output mcfd_pkg::frame_type frame
);

   logic [7:0]                   bytes_ff [mcfd_pkg::FRAME_LEN];
   logic [mcfd_pkg::COUNT_W-1:0] count_ff;
   logic [mcfd_pkg::COUNT_W-1:0] count_in;
   logic                         store;

   assign store = byte_we && (count_ff < mcfd_pkg::COUNT_W'(mcfd_pkg::FRAME_LEN));

   always_comb begin
      count_in = count_ff;
      if (idle_clr) begin
         count_in = '0;
      end else if (byte_we && (count_ff < mcfd_pkg::COUNT_MAX)) begin
         count_in = count_ff + 1'b1;
      end
   end

   always_comb begin
      for (int i = 0; i < mcfd_pkg::FRAME_LEN; i++) begin
         frame.bytes[i] = bytes_ff[i];
      end
      frame.full = (count_ff >= mcfd_pkg::COUNT_W'(mcfd_pkg::FRAME_LEN));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      if (store) begin
         bytes_ff[count_ff[mcfd_pkg::IDX_W-1:0]] <= rx_byte;
      end
   end

endmodule

// ----- design/mcfd_decoder.sv -----
// Frame check, settings registers and result register.
module mcfd_decoder (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 fire,
   input  mcfd_pkg::frame_type  frame,
   input  logic                 rsp_tready,
   output logic                 rsp_valid,
   output mcfd_pkg::result_type result
);

   mcfd_pkg::result_type set_ff;
   mcfd_pkg::result_type set_in;
   mcfd_pkg::result_type result_ff;
   logic                 valid_ff;
   logic [7:0]           hdr;
   logic [7:0]           tgt;
   logic [7:0]           val;
   logic [7:0]           sel;
   logic [1:0]           tw;

   assign hdr = frame.bytes[0];
   assign tgt = frame.bytes[1];
   assign val = frame.bytes[2];
   assign sel = frame.bytes[3];
   assign tw  = mcfd_pkg::two_way(val);

   assign rsp_valid = valid_ff;
   assign result    = result_ff;

   always_comb begin
      set_in         = set_ff;
      set_in.applied = 1'b0;
      if (fire && frame.full && (hdr == mcfd_pkg::HDR)) begin
         unique case (tgt)
            mcfd_pkg::TGT_BLDC: begin
               set_in.applied = 1'b1;
               unique case (sel)
                  mcfd_pkg::SEL_DUTY:  set_in.bldc_duty_pct = val;
                  mcfd_pkg::SEL_FREQ:  set_in.bldc_freq     = val;
                  mcfd_pkg::SEL_THIRD: set_in.bldc_volt     = val;
                  mcfd_pkg::SEL_RUN: begin
                     if (tw != mcfd_pkg::TW_NONE) begin
                        set_in.bldc_run = tw;
                     end else begin
                        set_in.applied = 1'b0;
                     end
                  end
                  default: set_in.applied = 1'b0;
               endcase
               if (set_in.applied) begin
                  set_in.last_target = mcfd_pkg::LAST_BLDC;
               end
            end
            mcfd_pkg::TGT_STEP: begin
               set_in.applied = 1'b1;
               unique case (sel)
                  mcfd_pkg::SEL_DUTY:  set_in.step_duty_pct  = val;
                  mcfd_pkg::SEL_FREQ:  set_in.step_freq      = val;
                  mcfd_pkg::SEL_THIRD: set_in.step_pulses    = val;
                  mcfd_pkg::SEL_MICRO: set_in.step_microstep = val;
                  mcfd_pkg::SEL_RUN: begin
                     if (tw != mcfd_pkg::TW_NONE) begin
                        set_in.step_run = tw;
                     end else begin
                        set_in.applied = 1'b0;
                     end
                  end
                  mcfd_pkg::SEL_DIR: begin
                     if (tw != mcfd_pkg::TW_NONE) begin
                        set_in.step_dir = tw;
                     end else begin
                        set_in.applied = 1'b0;
                     end
                  end
                  default: set_in.applied = 1'b0;
               endcase
               if (set_in.applied) begin
                  set_in.last_target = mcfd_pkg::LAST_STEP;
               end
            end
            default: set_in.applied = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         set_ff   <= '0;
         valid_ff <= 1'b0;
      end else begin
         set_ff <= set_in;
         if (fire) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
      if (fire) begin
         result_ff <= set_in;
      end
   end

endmodule

// ----- bench/tb_motor_command_frame_decoder_top.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for motor_command_frame_decoder_top with directed and random frames.
module tb_motor_command_frame_decoder_top;

   localparam int ITEM_TARGET  = 650;
   localparam int DIRECTED_N   = 23;
   localparam int HOLD_CYCLES  = 300;
   localparam int DRAIN_CYCLES = 10;

   typedef struct packed {
      logic                 kind;
      logic [7:0]           data;
      logic                 fixed;
      mcfd_pkg::result_type want;
   } directed_row_type;

   localparam mcfd_pkg::result_type NO_SNAP = '0;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;
   logic        req_tuser = mcfd_pkg::KIND_BYTE;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [71:0] rsp_tdata;

   // settings mirror and frame store of the predictor
   logic [7:0]                   frame_store [mcfd_pkg::FRAME_LEN];
   logic [mcfd_pkg::COUNT_W-1:0] frame_count = '0;
   mcfd_pkg::result_type         held_settings = '0;

   mcfd_pkg::result_type pending_snapshots [$];
   int                   field_errors   = 0;
   int                   snapshots_seen = 0;
   int                   items_sent     = 0;

   // rows: kind, byte, fixed expectation flag, fixed snapshot
   directed_row_type directed_tab [DIRECTED_N] = '{
      {mcfd_pkg::KIND_IDLE, 8'h00, 1'b1, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::HDR,       1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::TGT_BLDC,  1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, 8'hFF,               1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::SEL_DUTY,  1'b0, NO_SNAP},
      {mcfd_pkg::KIND_IDLE, 8'hFF, 1'b1,
       {1'b1, mcfd_pkg::LAST_BLDC, 8'h00, mcfd_pkg::TW_NONE, mcfd_pkg::TW_NONE, 8'h00,
        8'h00, 8'h00, mcfd_pkg::TW_NONE, 8'h00, 8'h00, 8'hFF}},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::HDR,       1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::TGT_BLDC,  1'b0, NO_SNAP},
      {mcfd_pkg::KIND_IDLE, 8'h00, 1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::HDR,       1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::TGT_STEP,  1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, 8'h00,               1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::SEL_DIR,   1'b0, NO_SNAP},
      {mcfd_pkg::KIND_IDLE, 8'h00, 1'b1,
       {1'b0, mcfd_pkg::LAST_BLDC, 8'h00, mcfd_pkg::TW_NONE, mcfd_pkg::TW_NONE, 8'h00,
        8'h00, 8'h00, mcfd_pkg::TW_NONE, 8'h00, 8'h00, 8'hFF}},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::HDR,       1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::TGT_STEP,  1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::VAL_OFF,   1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, mcfd_pkg::SEL_RUN,   1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, 8'hFF,               1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, 8'h00,               1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, 8'hFF,               1'b0, NO_SNAP},
      {mcfd_pkg::KIND_BYTE, 8'h00,               1'b0, NO_SNAP},
      {mcfd_pkg::KIND_IDLE, 8'h5A, 1'b1,
       {1'b1, mcfd_pkg::LAST_STEP, 8'h00, mcfd_pkg::TW_NONE, mcfd_pkg::TW_OFF, 8'h00,
        8'h00, 8'h00, mcfd_pkg::TW_NONE, 8'h00, 8'h00, 8'hFF}}
   };

   motor_command_frame_decoder_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic logic [1:0] start_stop_code(input logic [7:0] v);
      if (v == mcfd_pkg::VAL_ON) return mcfd_pkg::TW_ON;
      if (v == mcfd_pkg::VAL_OFF) return mcfd_pkg::TW_OFF;
      return mcfd_pkg::TW_NONE;
   endfunction

   // advance the predictor by one transaction; an idle yields a snapshot
   task automatic decode_transaction(input logic kind, input logic [7:0] data,
                                     output bit emits, output mcfd_pkg::result_type snap);
      logic       ok;
      logic [7:0] val;
      logic [7:0] sel;
      logic [1:0] ss;
      emits = 1'b0;
      snap  = '0;
      if (kind == mcfd_pkg::KIND_BYTE) begin
         if (frame_count < mcfd_pkg::FRAME_LEN)
            frame_store[frame_count[mcfd_pkg::IDX_W-1:0]] = data;
         if (frame_count < mcfd_pkg::COUNT_MAX) frame_count = frame_count + 1'b1;
      end else begin
         ok = 1'b0;
         if (frame_count >= mcfd_pkg::FRAME_LEN && frame_store[0] == mcfd_pkg::HDR) begin
            val = frame_store[2];
            sel = frame_store[3];
            ss  = start_stop_code(val);
            if (frame_store[1] == mcfd_pkg::TGT_BLDC) begin
               ok = 1'b1;
               case (sel)
                  mcfd_pkg::SEL_DUTY:  held_settings.bldc_duty_pct = val;
                  mcfd_pkg::SEL_FREQ:  held_settings.bldc_freq = val;
                  mcfd_pkg::SEL_THIRD: held_settings.bldc_volt = val;
                  mcfd_pkg::SEL_RUN:
                     if (ss != mcfd_pkg::TW_NONE) held_settings.bldc_run = ss; else ok = 1'b0;
                  default:   ok = 1'b0;
               endcase
               if (ok) held_settings.last_target = mcfd_pkg::LAST_BLDC;
            end else if (frame_store[1] == mcfd_pkg::TGT_STEP) begin
               ok = 1'b1;
               case (sel)
                  mcfd_pkg::SEL_DUTY:  held_settings.step_duty_pct = val;
                  mcfd_pkg::SEL_FREQ:  held_settings.step_freq = val;
                  mcfd_pkg::SEL_THIRD: held_settings.step_pulses = val;
                  mcfd_pkg::SEL_RUN:
                     if (ss != mcfd_pkg::TW_NONE) held_settings.step_run = ss; else ok = 1'b0;
                  mcfd_pkg::SEL_DIR:
                     if (ss != mcfd_pkg::TW_NONE) held_settings.step_dir = ss; else ok = 1'b0;
                  mcfd_pkg::SEL_MICRO: held_settings.step_microstep = val;
                  default:   ok = 1'b0;
               endcase
               if (ok) held_settings.last_target = mcfd_pkg::LAST_STEP;
            end
         end
         frame_count  = '0;
         snap         = held_settings;
         snap.applied = ok;
         emits        = 1'b1;
      end
   endtask

   task automatic send_transaction(input logic kind, input logic [7:0] data,
                                   input logic fixed, input mcfd_pkg::result_type want);
      bit                   emits;
      mcfd_pkg::result_type snap;
      // no random gaps in the middle stretch
      if ((items_sent < 250 || items_sent >= 400) && $urandom_range(0, 99) < 12) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= kind;
      req_tdata  <= data;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      decode_transaction(kind, data, emits, snap);
      if (emits) pending_snapshots.push_back(fixed ? want : snap);
   endtask

   task automatic send_random_frame();
      int         len;
      logic [7:0] fb [mcfd_pkg::FRAME_LEN];
      if ($urandom_range(0, 99) < 15) begin
         len = int'($urandom_range(0, 9));
         repeat (len) send_transaction(mcfd_pkg::KIND_BYTE, 8'($urandom_range(0, 255)),
                                       1'b0, NO_SNAP);
      end else begin
         fb[0] = mcfd_pkg::HDR;
         if ($urandom_range(0, 99) < 90)
            fb[1] = $urandom_range(0, 1) ? mcfd_pkg::TGT_BLDC : mcfd_pkg::TGT_STEP;
         else fb[1] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 35)
            fb[2] = $urandom_range(0, 1) ? mcfd_pkg::VAL_ON : mcfd_pkg::VAL_OFF;
         else fb[2] = 8'($urandom_range(0, 255));
         if ($urandom_range(0, 99) < 85) begin
            case ($urandom_range(0, 5))
               0:       fb[3] = mcfd_pkg::SEL_DUTY;
               1:       fb[3] = mcfd_pkg::SEL_FREQ;
               2:       fb[3] = mcfd_pkg::SEL_THIRD;
               3:       fb[3] = mcfd_pkg::SEL_RUN;
               4:       fb[3] = mcfd_pkg::SEL_DIR;
               default: fb[3] = mcfd_pkg::SEL_MICRO;
            endcase
         end else begin
            fb[3] = 8'($urandom_range(0, 255));
         end
         case ($urandom_range(0, 99)) inside
            [0:74]:  len = mcfd_pkg::FRAME_LEN;
            [75:86]: len = int'($urandom_range(0, mcfd_pkg::FRAME_LEN - 1));
            default: len = int'($urandom_range(mcfd_pkg::FRAME_LEN + 1, 9));
         endcase
         for (int i = 0; i < len; i++) begin
            send_transaction(mcfd_pkg::KIND_BYTE,
                             (i < mcfd_pkg::FRAME_LEN) ? fb[i] : 8'($urandom_range(0, 255)),
                             1'b0, NO_SNAP);
         end
      end
      send_transaction(mcfd_pkg::KIND_IDLE, 8'($urandom_range(0, 255)), 1'b0, NO_SNAP);
   endtask

   task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
      if (got !== want) begin
         field_errors++;
         if (field_errors <= 10)
            $display("snapshot %0d: %s expected 0x%02h got 0x%02h",
                     snapshots_seen, name, want, got);
      end
   endtask

   always @(posedge clock) begin : snapshot_monitor
      mcfd_pkg::result_type got;
      mcfd_pkg::result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = rsp_tdata[64:0];
         if (pending_snapshots.size() == 0) begin
            field_errors++;
            if (field_errors <= 10)
               $display("snapshot %0d: unexpected transaction 0x%018h", snapshots_seen, rsp_tdata);
         end else begin
            want = pending_snapshots.pop_front();
            check_field("bldc_duty_pct",  want.bldc_duty_pct,      got.bldc_duty_pct);
            check_field("bldc_freq",      want.bldc_freq,          got.bldc_freq);
            check_field("bldc_volt",      want.bldc_volt,          got.bldc_volt);
            check_field("bldc_run",       8'(want.bldc_run),       8'(got.bldc_run));
            check_field("step_duty_pct",  want.step_duty_pct,      got.step_duty_pct);
            check_field("step_freq",      want.step_freq,          got.step_freq);
            check_field("step_pulses",    want.step_pulses,        got.step_pulses);
            check_field("step_run",       8'(want.step_run),       8'(got.step_run));
            check_field("step_dir",       8'(want.step_dir),       8'(got.step_dir));
            check_field("step_microstep", want.step_microstep,     got.step_microstep);
            check_field("last_target",    8'(want.last_target),    8'(got.last_target));
            check_field("applied",        8'(want.applied),        8'(got.applied));
            check_field("padding",        8'h00,                   {1'b0, rsp_tdata[71:65]});
         end
         snapshots_seen++;
      end
   end

   // result side: random back-pressure, one long hold-off, one stretch always ready
   initial begin : rsp_ready_driver
      bit held_off;
      held_off = 1'b0;
      while (reset) @(posedge clock);
      forever begin
         @(posedge clock);
         if (!held_off && snapshots_seen >= 40) begin
            held_off = 1'b1;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         if (snapshots_seen >= 90 && snapshots_seen < 150) rsp_tready <= 1'b1;
         else rsp_tready <= ($urandom_range(0, 99) >= 12);
      end
   end

   initial begin : stimulus
      bit paused;
      paused = 1'b0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      foreach (directed_tab[i])
         send_transaction(directed_tab[i].kind, directed_tab[i].data,
                          directed_tab[i].fixed, directed_tab[i].want);
      while (items_sent < ITEM_TARGET) begin
         send_random_frame();
         if (!paused && items_sent >= 500) begin
            // let the pipe drain completely before carrying on
            paused = 1'b1;
            req_tvalid <= 1'b0;
            @(posedge clock);
            while (pending_snapshots.size() != 0) @(posedge clock);
         end
      end
      req_tvalid <= 1'b0;
      while (pending_snapshots.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (field_errors == 0 && pending_snapshots.size() == 0)
         $display("motor_command_frame_decoder_top regression: pass");
      else
         $display("motor_command_frame_decoder_top regression: fail");
      $finish;
   end

   initial begin : watchdog
      #(12 * 200000);
      $display("motor_command_frame_decoder_top regression: fail");
      $finish;
   end

endmodule

// ----- filelist.f -----
design/mcfd_pkg.sv
design/mcfd_in_reg.sv
design/mcfd_frame_buf.sv
design/mcfd_decoder.sv
design/motor_command_frame_decoder_top.sv
bench/tb_motor_command_frame_decoder_top.sv
